FILE: rtl/mpq_pkg.sv
// Shared types, codes and sizes for the sorted minimum priority queue.
// Used by mpq_cell and min_priority_queue_sorted_unit; depends on nothing.
package mpq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OpW      = 2;
  localparam int unsigned StW      = 2;

  localparam int unsigned InDataW  = ((OpW + KeyW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((StW + KeyW + CntW + 7) / 8) * 8;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_PEEK   = 2'd2;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_FULL  = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [KeyW-1:0] key_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } mpq_cmd_t;

endpackage

FILE: rtl/mpq_cell.sv
// One cell of the sorted key row: holds one key and trades it with its neighbors.
// Depends on mpq_pkg.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic     clk_i,
  input  mpq_cmd_t cmd_i,
  input  logic     occ_i,        // this cell holds a live key
  input  key_t     left_key_i,   // key of the cell one place lower
  input  logic     left_gt_i,    // lower cell holds a key above the new key
  input  key_t     right_key_i,  // key of the cell one place higher
  output key_t     key_o,
  output logic     gt_o
);

  key_t key_q, key_d;

  assign gt_o = occ_i && (key_q > cmd_i.key);

  always_comb begin
    key_d = key_q;
    if (cmd_i.ins) begin
      // The lower neighbor moving up wins; otherwise the new key lands in the
      // first cell that holds a larger key or no key at all.
      if (left_gt_i) begin
        key_d = left_key_i;
      end else if (gt_o || !occ_i) begin
        key_d = cmd_i.key;
      end
    end else if (cmd_i.del) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

FILE: rtl/min_priority_queue_sorted_unit.sv
// Top level of the sorted minimum priority queue: a row of key cells, the key
// count and the result register. Depends on mpq_pkg and mpq_cell.
//
// Usage: each item on the s_axis channel is one operation (insert, delete
// minimum or peek minimum) and yields exactly one result item on m_axis with
// a status, a key and the number of keys held after the step.
// The result is registered and is valid in the cycle after acceptance.
// One item is taken per cycle while the result side does not stall. Every cell compares its key with the new
// key and shifts toward its neighbor in the same cycle, so the row settles an
// insert or a delete at the edge that accepts it.
// The result sits in an output register. A new item is taken while that
// register is empty or being emptied in the same cycle; when the receiver
// stalls, the held result stays and s_axis_tready_o falls.
// Reset empties the queue (count zero) and clears the output valid. Key cells
// are not cleared; keys in cells above the count never reach the result.
// Insert into a full queue returns status full with key zero; delete or peek
// on an empty queue returns status empty with key zero. Operation code 3 does
// nothing and returns status ok with key zero.
module min_priority_queue_sorted_unit
  import mpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // operation[1:0], key_in[33:2]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // status[1:0], key_out[33:2],
                                                // occupancy[40:34]
);

  logic [OpW-1:0]  op;
  key_t            key_in;
  logic            accept;
  logic            full, empty;
  logic            ins_ok, del_ok;
  mpq_cmd_t        cmd;
  logic [CntW-1:0] count_q, count_d;
  logic            valid_q;
  logic [StW-1:0]  status_q, status_d;
  key_t            key_out_q, key_out_d;

  key_t            cell_key [Capacity];
  logic            cell_gt  [Capacity];
  logic            cell_occ [Capacity];

  assign op     = s_axis_tdata_i[OpW-1:0];
  assign key_in = s_axis_tdata_i[OpW+KeyW-1:OpW];

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full   = (count_q == CntW'(Capacity));
  assign empty  = (count_q == '0);
  assign ins_ok = accept && (op == OP_INSERT) && !full;
  assign del_ok = accept && (op == OP_DELETE) && !empty;

  assign cmd.ins = ins_ok;
  assign cmd.del = del_ok;
  assign cmd.key = key_in;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    key_t left_key, right_key;
    logic left_gt;

    assign cell_occ[g] = (CntW'(g) < count_q);

    if (g == 0) begin : g_first
      assign left_key = key_in;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_key = cell_key[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == Capacity - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_notlast
      assign right_key = cell_key[g+1];
    end

    mpq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (cell_occ[g]),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (cell_key[g]),
      .gt_o        (cell_gt[g])
    );
  end

  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    key_out_d = '0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          key_out_d = key_in;
          count_d   = count_q + CntW'(1);
        end
      end
      OP_DELETE, OP_PEEK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          key_out_d = cell_key[0];
          if (op == OP_DELETE) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      key_out_q <= key_out_d;
    end
  end

  // The occupancy field reports the count after the step, which is count_q now.
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - StW - KeyW - CntW){1'b0}},
                            count_q, key_out_q, status_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("key count above capacity");

  a_idle_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("key count changed without an accepted item");

  a_del_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_ok |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("delete did not lower the key count by one");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q == ST_FULL || status_q == ST_EMPTY)) |-> (key_out_q == '0))
    else $error("error result carries a nonzero key");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready_i) |=> (valid_q && $stable(count_q)))
    else $error("stalled result lost or queue changed under stall");

endmodule

FILE: tb/sv/tb_min_priority_queue_sorted_unit.sv
// Self-checking testbench for min_priority_queue_sorted_unit: a directed table, then phased
// random fill, drain and mixed traffic, checked against typed results or a queue-based model of the keys.
// Depends on mpq_pkg and the RTL of the unit.
module tb_min_priority_queue_sorted_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  localparam logic [OpW-1:0] OP_NONE = 2'd3;
  localparam int RandomItems = 1025;
  localparam int HoldCycles  = 300;
  localparam int TailCycles  = 20;
  localparam int TimeoutNs   = 2_000_000;

  typedef struct packed {
    logic [StW-1:0]  status;
    key_t            key;
    logic [CntW-1:0] occupancy;
  } pq_result_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    key_t           key;
    logic           typed;
    pq_result_t     result;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  localparam pq_result_t NoResult = '0;

  // Rows with a typed result are checked against it; the others against the model.
  localparam stim_row_t DirectedRows [25] = '{
    '{OP_PEEK,   32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
    '{OP_DELETE, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
    '{OP_NONE,   32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 7'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_OK,    32'h7FFF_FFFF, 7'd1}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 7'd2}},
    '{OP_PEEK,   32'h5A5A_5A5A, 1'b1, '{ST_OK,    32'h8000_0000, 7'd2}},
    '{OP_NONE,   32'h1234_5678, 1'b1, '{ST_OK,    32'h0000_0000, 7'd2}},
    '{OP_INSERT, 32'h0000_0000, 1'b0, NoResult},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, NoResult},
    '{OP_INSERT, 32'h0000_0000, 1'b0, NoResult},
    '{OP_INSERT, 32'h0000_0001, 1'b0, NoResult},
    '{OP_INSERT, 32'h8000_0000, 1'b0, NoResult},
    '{OP_DELETE, 32'h0000_0000, 1'b0, NoResult},
    '{OP_DELETE, 32'hFFFF_FFFF, 1'b0, NoResult},
    '{OP_DELETE, 32'h5555_5555, 1'b0, NoResult},
    '{OP_DELETE, 32'hAAAA_AAAA, 1'b0, NoResult},
    '{OP_DELETE, 32'h0000_0000, 1'b0, NoResult},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b0, NoResult},
    '{OP_DELETE, 32'h8000_0000, 1'b0, NoResult},
    '{OP_DELETE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
    '{OP_PEEK,   32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
    '{OP_INSERT, 32'h5555_5555, 1'b1, '{ST_OK,    32'h5555_5555, 7'd1}},
    '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, '{ST_OK,    32'hAAAA_AAAA, 7'd2}},
    '{OP_DELETE, 32'h0000_0000, 1'b0, NoResult},
    '{OP_DELETE, 32'hFFFF_FFFF, 1'b0, NoResult}
  };

  logic                clk_i;
  logic                rst_ni  = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data  = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  key_t       held_keys[$];
  pq_result_t pending_results[$];
  int         error_count = 0;
  int         hold_len    = 0;

  min_priority_queue_sorted_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("tb_min_priority_queue_sorted_unit: errors");
    $finish;
  end

  // Mostly back to back, sometimes a few cycles, now and then a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic key_t pick_key(input int mode);
    case (mode)
      0: return key_t'($urandom());
      // A narrow range gives many equal keys.
      1: return key_t'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: return key_t'(32'h8000_0000);
          1: return key_t'(32'h7FFF_FFFF);
          2: return key_t'(0);
          3: return key_t'(-1);
          default: return key_t'($urandom());
        endcase
      end
    endcase
  endfunction

  // Applies one operation to the held keys and returns the result it yields.
  function automatic pq_result_t apply_operation(input logic [OpW-1:0] op, input key_t key);
    pq_result_t res;
    int pos;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held_keys.size() >= int'(Capacity)) begin
          res.status = ST_FULL;
        end else begin
          // A new key goes behind every key equal to it.
          pos = 0;
          while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
          held_keys.insert(pos, key);
          res.key = key;
        end
      end
      OP_DELETE, OP_PEEK: begin
        if (held_keys.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = held_keys[0];
          if (op == OP_DELETE) held_keys.delete(0);
        end
      end
      default: ;
    endcase
    res.occupancy = CntW'(held_keys.size());
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result(input logic [OutDataW-1:0] data);
    pq_result_t got;
    pq_result_t want;
    got.status    = data[StW-1:0];
    got.key       = data[StW +: KeyW];
    got.occupancy = data[StW+KeyW +: CntW];
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result item with nothing pending, data %h", data));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.key !== want.key)
      report_mismatch($sformatf("key %h, want %h", got.key, want.key));
    if (got.occupancy !== want.occupancy)
      report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
  endtask

  // Offers one item, waits for it to be taken and records what it should yield.
  task automatic offer_item(input logic [OpW-1:0] op, input key_t key, input logic typed,
                            input pq_result_t typed_result, input bit no_gaps);
    int gap;
    pq_result_t predicted;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      s_data  <= InDataW'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= InDataW'({key, op});
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_operation(op, key);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) check_result(m_axis_tdata_o);
  end

  // Result side: ready bursts, short and long stalls, and the long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_len > 0) begin
        m_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else if ($urandom_range(0, 2) != 0) begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          random_sent;
    int          phase;
    int          len;
    int          r;
    int          key_mode;
    bit          no_gaps;
    phase_kind_t kind;
    logic [OpW-1:0] op;
    key_t        key;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      offer_item(DirectedRows[i].op, DirectedRows[i].key, DirectedRows[i].typed,
                 DirectedRows[i].result, 1'b0);

    random_sent = 0;
    phase = 0;
    while (random_sent < RandomItems) begin
      kind     = (phase == 0) ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
      len      = (phase == 0) ? 100 : $urandom_range(20, 110);
      key_mode = $urandom_range(0, 2);
      no_gaps  = (phase == 0) || ($urandom_range(0, 4) == 0);
      // The first fill runs into a long stall on the result side.
      if (phase == 0) hold_len = HoldCycles;
      if (phase % 4 == 3) begin
        s_valid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      for (int n = 0; n < len && random_sent < RandomItems; n++) begin
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL:  op = (r < 88) ? OP_INSERT : (r < 94) ? OP_DELETE :
                         (r < 97) ? OP_PEEK : OP_NONE;
          PH_DRAIN: op = (r < 10) ? OP_INSERT : (r < 80) ? OP_DELETE :
                         (r < 96) ? OP_PEEK : OP_NONE;
          default:  op = (r < 40) ? OP_INSERT : (r < 75) ? OP_DELETE :
                         (r < 96) ? OP_PEEK : OP_NONE;
        endcase
        key = pick_key(key_mode);
        offer_item(op, key, 1'b0, NoResult, no_gaps);
        random_sent++;
      end
      phase++;
    end
    s_valid <= 1'b0;

    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_min_priority_queue_sorted_unit: clean");
    end else begin
      $display("tb_min_priority_queue_sorted_unit: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mpq_pkg.sv
rtl/mpq_cell.sv
rtl/min_priority_queue_sorted_unit.sv
tb/sv/tb_min_priority_queue_sorted_unit.sv
